// ===== hw/rtl/stp_pkg.sv =====
// Shared types and constants for the sized text header parser.
package stp_pkg;

   // Character codes and field widths.
   localparam int CH_W      = 21;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int DIGIT_W   = 4;
   localparam int ACCUM_W   = 17;
   localparam int COUNT_W   = 7;

   localparam logic [COUNT_W-1:0] HEADER_LIMIT   = COUNT_W'(125);
   localparam logic [ACCUM_W-1:0] OVERFLOW_GUARD = ACCUM_W'(6553);

   localparam logic [CH_W-1:0] CH_SEMI  = CH_W'(8'h3B);
   localparam logic [CH_W-1:0] CH_COLON = CH_W'(8'h3A);
   localparam logic [CH_W-1:0] CH_EQUAL = CH_W'(8'h3D);
   localparam logic [CH_W-1:0] CH_ZERO  = CH_W'(8'h30);
   localparam logic [CH_W-1:0] CH_NINE  = CH_W'(8'h39);
   localparam logic [CH_W-1:0] CH_KEY_S = CH_W'(8'h73);
   localparam logic [CH_W-1:0] CH_KEY_W = CH_W'(8'h77);
   localparam logic [CH_W-1:0] CH_KEY_N = CH_W'(8'h6E);
   localparam logic [CH_W-1:0] CH_KEY_D = CH_W'(8'h64);
   localparam logic [CH_W-1:0] CH_KEY_V = CH_W'(8'h76);
   localparam logic [CH_W-1:0] CH_KEY_H = CH_W'(8'h68);

   // Token queue between the classifier and the parser.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      TK_OTHER,
      TK_DIGIT,
      TK_EQUAL,
      TK_COLON,
      TK_SEMI
   } tok_kind_type;

   typedef enum logic [2:0] {
      KEY_NONE,
      KEY_SCALE,
      KEY_WIDTH,
      KEY_NUM,
      KEY_DEN,
      KEY_VALIGN,
      KEY_HALIGN
   } key_class_type;

   typedef enum logic [1:0] {
      PH_KEY,
      PH_EQ,
      PH_FIRSTDIG,
      PH_DIGITS
   } phase_type;

   typedef struct packed {
      logic                first;
      tok_kind_type        kind;
      logic [DIGIT_W-1:0]  digit;
      key_class_type       key;
   } token_type;

endpackage

// ===== hw/rtl/stp_front.sv =====
// Request side: accepts characters and classifies each into a token.
module stp_front (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [stp_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tuser,
   input  logic                              q_full,
   output logic                              q_push,
   output stp_pkg::token_type                q_token
);

   logic [stp_pkg::CH_W-1:0] ch;

   assign ch         = req_tdata[stp_pkg::CH_W-1:0];
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_token.first = req_tuser;
      // Digits are 0x30..0x39, so the low nibble is the digit value.
      q_token.digit = ch[stp_pkg::DIGIT_W-1:0];

      if (ch inside {[stp_pkg::CH_ZERO:stp_pkg::CH_NINE]}) begin
         q_token.kind = stp_pkg::TK_DIGIT;
      end else if (ch == stp_pkg::CH_SEMI) begin
         q_token.kind = stp_pkg::TK_SEMI;
      end else if (ch == stp_pkg::CH_COLON) begin
         q_token.kind = stp_pkg::TK_COLON;
      end else if (ch == stp_pkg::CH_EQUAL) begin
         q_token.kind = stp_pkg::TK_EQUAL;
      end else begin
         q_token.kind = stp_pkg::TK_OTHER;
      end

      case (ch)
         stp_pkg::CH_KEY_S: q_token.key = stp_pkg::KEY_SCALE;
         stp_pkg::CH_KEY_W: q_token.key = stp_pkg::KEY_WIDTH;
         stp_pkg::CH_KEY_N: q_token.key = stp_pkg::KEY_NUM;
         stp_pkg::CH_KEY_D: q_token.key = stp_pkg::KEY_DEN;
         stp_pkg::CH_KEY_V: q_token.key = stp_pkg::KEY_VALIGN;
         stp_pkg::CH_KEY_H: q_token.key = stp_pkg::KEY_HALIGN;
         default:           q_token.key = stp_pkg::KEY_NONE;
      endcase
   end

endmodule

// ===== hw/rtl/stp_queue.sv =====
// Small token queue that decouples the classifier from the parser.
module stp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  stp_pkg::token_type  push_token,
   input  logic                pop,
   output logic                head_valid,
   output stp_pkg::token_type  head_token,
   output logic                full
);

   stp_pkg::token_type                    slot_ff [stp_pkg::QUEUE_DEPTH];
   logic [stp_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [stp_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [stp_pkg::QUEUE_CNT_W-1:0]       count_ff, count_in;
   logic                                  do_pop;

   assign head_valid = (count_ff != '0);
   assign head_token = slot_ff[rd_ptr_ff];
   assign full       = (count_ff == stp_pkg::QUEUE_CNT_W'(stp_pkg::QUEUE_DEPTH));
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

// ===== hw/rtl/stp_back.sv =====
// Parser core: walks the header tokens and registers the response.
module stp_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  stp_pkg::token_type                q_token,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [stp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser
);

   stp_pkg::phase_type               phase_ff, phase_in, phase_e;
   stp_pkg::key_class_type           key_ff, key_in, key_e;
   logic [stp_pkg::ACCUM_W-1:0]      accum_ff, accum_in, accum_e;
   logic [stp_pkg::COUNT_W-1:0]      count_ff, count_in, count_e;
   logic                             failed_ff, failed_in, failed_e;
   logic                             done_ff, done_in, done_e;
   logic [2:0]                       scale_ff, scale_in, scale_e;
   logic [2:0]                       width_ff, width_in, width_e;
   logic [3:0]                       num_ff, num_in, num_e;
   logic [3:0]                       den_ff, den_in, den_e;
   logic [1:0]                       valign_ff, valign_in, valign_e;
   logic [1:0]                       halign_ff, halign_in, halign_e;

   logic                             commit_bad;
   logic                             emit;
   logic                             ok;
   logic                             stall;
   logic                             rsp_valid_ff;
   logic [stp_pkg::RSP_DATA_W-1:0]   rsp_data_ff;
   logic                             rsp_user_ff;

   // A first character restarts the parser before it is looked at.
   always_comb begin
      if (q_token.first) begin
         phase_e  = stp_pkg::PH_KEY;
         key_e    = stp_pkg::KEY_NONE;
         accum_e  = '0;
         count_e  = '0;
         failed_e = 1'b0;
         done_e   = 1'b0;
         scale_e  = 3'd1;
         width_e  = '0;
         num_e    = '0;
         den_e    = '0;
         valign_e = '0;
         halign_e = '0;
      end else begin
         phase_e  = phase_ff;
         key_e    = key_ff;
         accum_e  = accum_ff;
         count_e  = count_ff;
         failed_e = failed_ff;
         done_e   = done_ff;
         scale_e  = scale_ff;
         width_e  = width_ff;
         num_e    = num_ff;
         den_e    = den_ff;
         valign_e = valign_ff;
         halign_e = halign_ff;
      end
   end

   // Range check of the value that just ended, for the current key.
   always_comb begin
      case (key_e)
         stp_pkg::KEY_SCALE:  commit_bad = (accum_e == '0) ||
                                           (accum_e > stp_pkg::ACCUM_W'(7));
         stp_pkg::KEY_WIDTH:  commit_bad = (accum_e > stp_pkg::ACCUM_W'(7));
         stp_pkg::KEY_NUM:    commit_bad = (accum_e > stp_pkg::ACCUM_W'(15));
         stp_pkg::KEY_DEN:    commit_bad = (accum_e > stp_pkg::ACCUM_W'(15));
         stp_pkg::KEY_VALIGN: commit_bad = (accum_e > stp_pkg::ACCUM_W'(2));
         stp_pkg::KEY_HALIGN: commit_bad = (accum_e > stp_pkg::ACCUM_W'(2));
         default:             commit_bad = 1'b0;
      endcase
   end

   always_comb begin
      phase_in  = phase_e;
      key_in    = key_e;
      accum_in  = accum_e;
      count_in  = count_e;
      failed_in = failed_e;
      done_in   = done_e;
      scale_in  = scale_e;
      width_in  = width_e;
      num_in    = num_e;
      den_in    = den_e;
      valign_in = valign_e;
      halign_in = halign_e;
      emit      = 1'b0;

      if (!done_e) begin
         if (q_token.kind == stp_pkg::TK_SEMI) begin
            if (!failed_e) begin
               if (phase_e == stp_pkg::PH_EQ || phase_e == stp_pkg::PH_FIRSTDIG) begin
                  failed_in = 1'b1;
               end else if (phase_e == stp_pkg::PH_DIGITS) begin
                  accum_in = '0;
                  if (commit_bad) begin
                     failed_in = 1'b1;
                  end else begin
                     case (key_e)
                        stp_pkg::KEY_SCALE:  scale_in  = accum_e[2:0];
                        stp_pkg::KEY_WIDTH:  width_in  = accum_e[2:0];
                        stp_pkg::KEY_NUM:    num_in    = accum_e[3:0];
                        stp_pkg::KEY_DEN:    den_in    = accum_e[3:0];
                        stp_pkg::KEY_VALIGN: valign_in = accum_e[1:0];
                        stp_pkg::KEY_HALIGN: halign_in = accum_e[1:0];
                        default:             ;
                     endcase
                  end
               end
            end
            if (!failed_in && den_in != '0 && num_in >= den_in) begin
               failed_in = 1'b1;
            end
            done_in = 1'b1;
            emit    = 1'b1;
         end else begin
            if (count_e <= stp_pkg::HEADER_LIMIT) begin
               count_in = count_e + 1'b1;
            end
            if (count_in > stp_pkg::HEADER_LIMIT) begin
               failed_in = 1'b1;
            end
            if (!failed_in) begin
               case (phase_e)
                  stp_pkg::PH_KEY: begin
                     key_in   = q_token.key;
                     accum_in = '0;
                     phase_in = stp_pkg::PH_EQ;
                  end
                  stp_pkg::PH_EQ: begin
                     if (q_token.kind == stp_pkg::TK_EQUAL) begin
                        phase_in = stp_pkg::PH_FIRSTDIG;
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
                  stp_pkg::PH_FIRSTDIG: begin
                     if (q_token.kind == stp_pkg::TK_DIGIT) begin
                        accum_in = stp_pkg::ACCUM_W'(q_token.digit);
                        phase_in = stp_pkg::PH_DIGITS;
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
                  default: begin
                     if (q_token.kind == stp_pkg::TK_DIGIT) begin
                        if (accum_e > stp_pkg::OVERFLOW_GUARD) begin
                           failed_in = 1'b1;
                        end else begin
                           accum_in = stp_pkg::ACCUM_W'(accum_e * stp_pkg::ACCUM_W'(10))
                                    + stp_pkg::ACCUM_W'(q_token.digit);
                        end
                     end else if (q_token.kind == stp_pkg::TK_COLON) begin
                        accum_in = '0;
                        phase_in = stp_pkg::PH_KEY;
                        if (commit_bad) begin
                           failed_in = 1'b1;
                        end else begin
                           case (key_e)
                              stp_pkg::KEY_SCALE:  scale_in  = accum_e[2:0];
                              stp_pkg::KEY_WIDTH:  width_in  = accum_e[2:0];
                              stp_pkg::KEY_NUM:    num_in    = accum_e[3:0];
                              stp_pkg::KEY_DEN:    den_in    = accum_e[3:0];
                              stp_pkg::KEY_VALIGN: valign_in = accum_e[1:0];
                              stp_pkg::KEY_HALIGN: halign_in = accum_e[1:0];
                              default:             ;
                           endcase
                        end
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
               endcase
            end
         end
      end
   end

   // Only a token that ends a header needs room in the response register.
   assign stall = q_valid && emit && rsp_valid_ff && !rsp_tready;
   assign q_pop = q_valid && !stall;
   assign ok    = !failed_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= stp_pkg::PH_KEY;
         key_ff    <= stp_pkg::KEY_NONE;
         accum_ff  <= '0;
         count_ff  <= '0;
         failed_ff <= 1'b0;
         done_ff   <= 1'b1;
         scale_ff  <= 3'd1;
         width_ff  <= '0;
         num_ff    <= '0;
         den_ff    <= '0;
         valign_ff <= '0;
         halign_ff <= '0;
      end else if (q_pop) begin
         phase_ff  <= phase_in;
         key_ff    <= key_in;
         accum_ff  <= accum_in;
         count_ff  <= count_in;
         failed_ff <= failed_in;
         done_ff   <= done_in;
         scale_ff  <= scale_in;
         width_ff  <= width_in;
         num_ff    <= num_in;
         den_ff    <= den_in;
         valign_ff <= valign_in;
         halign_ff <= halign_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && emit) begin
         rsp_user_ff <= ok;
         if (ok) begin
            rsp_data_ff <= {6'd0, halign_in, valign_in, den_in, num_in,
                            width_in, scale_in};
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== hw/rtl/sized_text_header_parser.sv =====
// Top level of the sized text header parser.
//
// One header character arrives per request on the req_ channel, the
// characters that follow the escape sequence prefix; req_tuser marks the
// first character of a header and restarts the parser. A response leaves on
// the rsp_ channel only when the closing ';' is parsed: rsp_tuser is 1 when
// the header passed every check, and rsp_tdata then carries the size and
// alignment fields, all zero otherwise. Characters after ';' are ignored
// until the next request that has req_tuser set.
// The classifier writes a token into a two-entry queue in the cycle a
// request is accepted; the parser takes it from the queue head and registers
// the response in the response register. The block takes one request per
// cycle while req_tready is high. When rsp_tready is low, the parser holds
// only a ';' token while the response register is full; the queue then
// fills and req_tready drops. After reset the parser is idle until a
// request with req_tuser set arrives, and the queue and response register
// are empty.
module sized_text_header_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // ch [20:0], zero [23:21]
   input  logic [stp_pkg::REQ_DATA_W-1:0]    req_tdata,
   // first [0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // scale [2:0], span_cells [5:3], numerator [9:6], denominator [13:10],
   // vert_align [15:14], horiz_align [17:16], zero [23:18]
   output logic [stp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // valid_res [0]
   output logic                              rsp_tuser
);

   logic                q_full;
   logic                q_push;
   logic                q_pop;
   logic                q_valid;
   stp_pkg::token_type  push_token;
   stp_pkg::token_type  head_token;

   stp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_token    (push_token)
   );

   stp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (push_token),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_token (head_token),
      .full       (q_full)
   );

   stp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_token    (head_token),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
